[hw/rtl/ppi_pkg.sv]
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared codes and field widths for the three-port parallel interface
// (basic I/O mode).
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 2;

  typedef logic [DataW-1:0] byte_t;
  typedef logic [AddrW-1:0] addr_t;

  // Bus operation codes
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Register addresses
  localparam addr_t ADDR_PORT_A = 2'd0;
  localparam addr_t ADDR_PORT_B = 2'd1;
  localparam addr_t ADDR_PORT_C = 2'd2;
  localparam addr_t ADDR_CTRL   = 2'd3;

  // Port that was driven by a write
  typedef enum logic [1:0] {
    STROBE_NONE = 2'd0,
    STROBE_A    = 2'd1,
    STROBE_B    = 2'd2,
    STROBE_C    = 2'd3
  } strobe_t;

  // Control word bit positions
  localparam int unsigned CTRL_MODE_SET_BIT = 7;
  localparam int unsigned CTRL_A_IN_BIT     = 4;
  localparam int unsigned CTRL_C_HI_IN_BIT  = 3;
  localparam int unsigned CTRL_B_IN_BIT     = 1;
  localparam int unsigned CTRL_C_LO_IN_BIT  = 0;

  // Mode word after reset: mode set flag only, every port output
  localparam byte_t MODE_RESET = 8'h80;
  localparam byte_t ALL_INPUT  = 8'hff;

endpackage

[hw/rtl/ppi_if.sv]
// ----------------------------------------------------------------------------
// ppi_if
// Valid/ready channels of the parallel interface: bus access items in,
// result items out.
// ----------------------------------------------------------------------------
interface ppi_req_if;
  import ppi_pkg::*;

  logic  valid;
  logic  ready;
  logic  op;
  addr_t addr;
  byte_t wr_data;
  byte_t pins_a;
  byte_t pins_b;
  byte_t pins_c;

  modport source (output valid, op, addr, wr_data, pins_a, pins_b, pins_c,
                  input ready);
  modport sink   (input valid, op, addr, wr_data, pins_a, pins_b, pins_c,
                  output ready);
endinterface

interface ppi_rsp_if;
  import ppi_pkg::*;

  logic       valid;
  logic       ready;
  byte_t      rd_data;
  byte_t      drive_a;
  byte_t      drive_b;
  byte_t      drive_c;
  logic [1:0] strobe_port;
  byte_t      strobe_data;

  modport source (output valid, rd_data, drive_a, drive_b, drive_c, strobe_port,
                  strobe_data, input ready);
  modport sink   (input valid, rd_data, drive_a, drive_b, drive_c, strobe_port,
                  strobe_data, output ready);
endinterface

[hw/rtl/parallel_port_interface_mode0.sv]
// ----------------------------------------------------------------------------
// parallel_port_interface_mode0
// Three-port parallel interface, basic I/O mode, one bus access per item.
// ----------------------------------------------------------------------------
// Each accepted item is one bus read or write and returns exactly one result
// item in the following cycle through a result register. An item can be accepted on
// every cycle: the block takes a new item whenever the result register is
// empty or is being emptied in the same cycle, so the rate is one item per
// clock while the output side takes results, set by the single result register.
// Control words update the port directions; bit set/reset writes act like a
// port C write. Handshake modes 1 and 2 are only kept in the mode word.
module parallel_port_interface_mode0 (
  input logic    clk,
  input logic    rst,
  ppi_req_if.sink   req,
  ppi_rsp_if.source rsp
);
  import ppi_pkg::*;

  // Port state
  byte_t latch_a, latch_b, latch_c;
  byte_t latch_a_next, latch_b_next, latch_c_next;
  logic  a_in, b_in, c_lo_in, c_hi_in;
  logic  a_in_next, b_in_next, c_lo_in_next, c_hi_in_next;
  byte_t mode_word, mode_word_next;

  // Result register
  logic    rsp_valid;
  byte_t   rd_data, rd_data_next;
  byte_t   drive_a, drive_b, drive_c;
  strobe_t strobe_port, strobe_port_next;
  byte_t   strobe_data, strobe_data_next;

  byte_t mask_a, mask_b, mask_c;
  byte_t mask_a_next, mask_b_next, mask_c_next;
  byte_t c_bsr;
  logic  accept;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Input masks from the direction bits
  assign mask_a = {DataW{a_in}};
  assign mask_b = {DataW{b_in}};
  assign mask_c = {{(DataW/2){c_hi_in}}, {(DataW/2){c_lo_in}}};
  assign mask_a_next = {DataW{a_in_next}};
  assign mask_b_next = {DataW{b_in_next}};
  assign mask_c_next = {{(DataW/2){c_hi_in_next}}, {(DataW/2){c_lo_in_next}}};

  // Access decode and state update
  always_comb begin
    latch_a_next     = latch_a;
    latch_b_next     = latch_b;
    latch_c_next     = latch_c;
    a_in_next        = a_in;
    b_in_next        = b_in;
    c_lo_in_next     = c_lo_in;
    c_hi_in_next     = c_hi_in;
    mode_word_next   = mode_word;
    rd_data_next     = '0;
    strobe_port_next = STROBE_NONE;
    strobe_data_next = '0;
    c_bsr            = latch_c;
    c_bsr[req.wr_data[3:1]] = req.wr_data[0];

    if (req.op == OP_WRITE) begin
      case (req.addr)
        ADDR_PORT_A: begin
          latch_a_next = req.wr_data;
          if (mask_a != ALL_INPUT) begin
            strobe_port_next = STROBE_A;
            strobe_data_next = req.wr_data & ~mask_a;
          end
        end
        ADDR_PORT_B: begin
          latch_b_next = req.wr_data;
          if (mask_b != ALL_INPUT) begin
            strobe_port_next = STROBE_B;
            strobe_data_next = req.wr_data & ~mask_b;
          end
        end
        ADDR_PORT_C: begin
          latch_c_next = req.wr_data;
          if (mask_c != ALL_INPUT) begin
            strobe_port_next = STROBE_C;
            strobe_data_next = req.wr_data & ~mask_c;
          end
        end
        ADDR_CTRL: begin
          if (req.wr_data[CTRL_MODE_SET_BIT]) begin
            mode_word_next = req.wr_data;
            a_in_next      = req.wr_data[CTRL_A_IN_BIT];
            b_in_next      = req.wr_data[CTRL_B_IN_BIT];
            c_lo_in_next   = req.wr_data[CTRL_C_LO_IN_BIT];
            c_hi_in_next   = req.wr_data[CTRL_C_HI_IN_BIT];
          end else begin
            // bit set/reset on port C
            latch_c_next = c_bsr;
            if (mask_c != ALL_INPUT) begin
              strobe_port_next = STROBE_C;
              strobe_data_next = c_bsr & ~mask_c;
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (req.addr)
        ADDR_PORT_A: rd_data_next = (req.pins_a & mask_a) | (latch_a & ~mask_a);
        ADDR_PORT_B: rd_data_next = (req.pins_b & mask_b) | (latch_b & ~mask_b);
        ADDR_PORT_C: rd_data_next = (req.pins_c & mask_c) | (latch_c & ~mask_c);
        default:     rd_data_next = mode_word;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      latch_a   <= '0;
      latch_b   <= '0;
      latch_c   <= '0;
      a_in      <= 1'b0;
      b_in      <= 1'b0;
      c_lo_in   <= 1'b0;
      c_hi_in   <= 1'b0;
      mode_word <= MODE_RESET;
    end else if (accept) begin
      latch_a   <= latch_a_next;
      latch_b   <= latch_b_next;
      latch_c   <= latch_c_next;
      a_in      <= a_in_next;
      b_in      <= b_in_next;
      c_lo_in   <= c_lo_in_next;
      c_hi_in   <= c_hi_in_next;
      mode_word <= mode_word_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload, sampled after this item's update
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data     <= rd_data_next;
      drive_a     <= latch_a_next | mask_a_next;
      drive_b     <= latch_b_next | mask_b_next;
      drive_c     <= latch_c_next | mask_c_next;
      strobe_port <= strobe_port_next;
      strobe_data <= strobe_data_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.rd_data     = rd_data;
  assign rsp.drive_a     = drive_a;
  assign rsp.drive_b     = drive_b;
  assign rsp.drive_c     = drive_c;
  assign rsp.strobe_port = strobe_port;
  assign rsp.strobe_data = strobe_data;

  // Checks
  a_no_strobe_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (strobe_port == STROBE_NONE) |-> (strobe_data == '0))
    else $error("strobe data set without a strobed port");

  a_read_no_strobe: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == OP_READ) |=> (strobe_port == STROBE_NONE))
    else $error("read access produced a strobe");

  a_mode_set_no_strobe: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == OP_WRITE) && (req.addr == ADDR_CTRL) &&
    req.wr_data[CTRL_MODE_SET_BIT] |=> (strobe_port == STROBE_NONE) && (rd_data == '0))
    else $error("control word produced a strobe or read data");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req.ready)
    else $error("empty result register but not ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid)
    else $error("result valid straight after reset");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-port parallel interface in basic I/O
// mode. Bus accesses go in over the request channel. A behavioural
// predictor of latches, direction masks and mode word computes each result
// item, and each result item is checked field by field in arrival order.
// Directed accesses come first, then random traffic under several idle
// patterns, then a long output stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb;
  import ppi_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTED = 10;

  typedef struct packed {
    byte_t   rd_data;
    byte_t   drive_a;
    byte_t   drive_b;
    byte_t   drive_c;
    strobe_t strobe_port;
    byte_t   strobe_data;
  } ppi_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppi_req_if req_ch ();
  ppi_rsp_if rsp_ch ();

  parallel_port_interface_mode0 u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predictor state
  byte_t port_latch [3];
  byte_t port_in_mask [3];
  byte_t mode_reg;

  ppi_result_t expected_results [$];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Expected result of one bus access; updates the predictor state
  function automatic ppi_result_t predict_access(op_t op, addr_t addr, byte_t data,
                                                 byte_t pa, byte_t pb, byte_t pc);
    ppi_result_t r;
    byte_t       pins [3];
    byte_t       sel;
    byte_t       wv;
    logic        do_write;
    int unsigned wp;
    r        = '0;
    pins[0]  = pa;
    pins[1]  = pb;
    pins[2]  = pc;
    do_write = 1'b0;
    wp       = 0;
    wv       = '0;
    if (op == OP_WRITE) begin
      if (addr != ADDR_CTRL) begin
        do_write = 1'b1;
        wp       = int'(addr);
        wv       = data;
      end else if (data[CTRL_MODE_SET_BIT]) begin
        mode_reg        = data;
        port_in_mask[0] = data[CTRL_A_IN_BIT] ? ALL_INPUT : '0;
        port_in_mask[1] = data[CTRL_B_IN_BIT] ? ALL_INPUT : '0;
        port_in_mask[2] = {{4{data[CTRL_C_HI_IN_BIT]}}, {4{data[CTRL_C_LO_IN_BIT]}}};
      end else begin
        // bit set/reset on port C
        sel      = byte_t'(1) << data[3:1];
        do_write = 1'b1;
        wp       = int'(ADDR_PORT_C);
        wv       = data[0] ? (port_latch[2] | sel) : (port_latch[2] & ~sel);
      end
    end else begin
      r.rd_data = (addr == ADDR_CTRL) ? mode_reg :
                  ((pins[addr] & port_in_mask[addr]) | (port_latch[addr] & ~port_in_mask[addr]));
    end
    if (do_write) begin
      port_latch[wp] = wv;
      if (port_in_mask[wp] != ALL_INPUT) begin
        r.strobe_port = strobe_t'(2'(wp + 1));
        r.strobe_data = wv & ~port_in_mask[wp];
      end
    end
    r.drive_a = port_latch[0] | port_in_mask[0];
    r.drive_b = port_latch[1] | port_in_mask[1];
    r.drive_c = port_latch[2] | port_in_mask[2];
    return r;
  endfunction

  // Offer one item, wait for acceptance, queue its expected result
  task automatic send_access(op_t op, addr_t addr, byte_t data,
                             byte_t pa, byte_t pb, byte_t pc);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.op      <= op;
    req_ch.addr    <= addr;
    req_ch.wr_data <= data;
    req_ch.pins_a  <= pa;
    req_ch.pins_b  <= pb;
    req_ch.pins_c  <= pc;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_results.push_back(predict_access(op, addr, data, pa, pb, pc));
  endtask

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
  endtask

  // Output side ready, with random stalls and a counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin : check_results
    ppi_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("%0t: result item with nothing expected", $realtime);
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.rd_data !== want.rd_data)
          note_mismatch("rd_data", want.rd_data, rsp_ch.rd_data);
        if (rsp_ch.drive_a !== want.drive_a)
          note_mismatch("drive_a", want.drive_a, rsp_ch.drive_a);
        if (rsp_ch.drive_b !== want.drive_b)
          note_mismatch("drive_b", want.drive_b, rsp_ch.drive_b);
        if (rsp_ch.drive_c !== want.drive_c)
          note_mismatch("drive_c", want.drive_c, rsp_ch.drive_c);
        if (rsp_ch.strobe_port !== want.strobe_port)
          note_mismatch("strobe_port", want.strobe_port, rsp_ch.strobe_port);
        if (rsp_ch.strobe_data !== want.strobe_data)
          note_mismatch("strobe_data", want.strobe_data, rsp_ch.strobe_data);
      end
    end
  end

  // Reset values, extremes, direction changes, bit set/reset, mode reads
  task automatic test_reset_and_extremes();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_access(OP_READ,  ADDR_CTRL,   8'h00, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_A, 8'h00, 8'hff, 8'hff, 8'hff);
    send_access(OP_WRITE, ADDR_PORT_A, 8'hff, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_PORT_B, 8'h00, 8'hff, 8'hff, 8'hff);
    send_access(OP_WRITE, ADDR_PORT_C, 8'ha5, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_A, 8'h00, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_C, 8'h00, 8'hff, 8'hff, 8'h5a);
    // every port input
    send_access(OP_WRITE, ADDR_CTRL,   8'h9b, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_A, 8'h00, 8'h3c, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_B, 8'h00, 8'h00, 8'hc3, 8'h00);
    send_access(OP_READ,  ADDR_PORT_C, 8'h00, 8'h00, 8'h00, 8'h5a);
    // writes to all-input ports: latch only, no strobe
    send_access(OP_WRITE, ADDR_PORT_A, 8'h12, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_PORT_C, 8'hff, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_CTRL,   8'h0e, 8'h00, 8'h00, 8'h00);
    // C low input
    send_access(OP_WRITE, ADDR_CTRL,   8'h81, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_PORT_C, 8'hff, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_C, 8'h00, 8'hff, 8'hff, 8'h00);
    // C high input, bit set/reset on bit 0
    send_access(OP_WRITE, ADDR_CTRL,   8'h88, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_CTRL,   8'h00, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_CTRL,   8'h01, 8'h00, 8'h00, 8'h00);
    // handshake mode bits are only recorded
    send_access(OP_WRITE, ADDR_CTRL,   8'he4, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_CTRL,   8'h00, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_CTRL,   8'h80, 8'h00, 8'h00, 8'h00);
    send_access(OP_WRITE, ADDR_PORT_B, 8'h5a, 8'h00, 8'h00, 8'h00);
    send_access(OP_READ,  ADDR_PORT_B, 8'h00, 8'hff, 8'hff, 8'hff);
  endtask

  // Random accesses with the given idle pattern
  task automatic test_random_traffic(int unsigned n, int unsigned tx_pct, int unsigned rx_pct);
    op_t   op;
    addr_t addr;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) begin
      op   = op_t'($urandom_range(1));
      addr = addr_t'($urandom_range(3));
      send_access(op, addr, byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                  byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
    end
  endtask

  // Long output hold-off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 200;
    test_random_traffic(40, 0, 0);
  endtask

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_READ;
    req_ch.addr    = ADDR_PORT_A;
    req_ch.wr_data = '0;
    req_ch.pins_a  = '0;
    req_ch.pins_b  = '0;
    req_ch.pins_c  = '0;
    for (int i = 0; i < 3; i++) begin
      port_latch[i]   = '0;
      port_in_mask[i] = '0;
    end
    mode_reg = MODE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_extremes();
    test_random_traffic(240, 0, 0);
    test_random_traffic(220, 49, 0);
    test_random_traffic(220, 0, 49);
    test_random_traffic(220, 31, 31);
    test_output_backpressure();

    // drain
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
